### src/usan_pkg.sv
// types, constants and helper functions shared by the utf-8 sanitizer
`timescale 1ns / 1ps
package usan_pkg;

  // request kinds on the input tuser
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_EOS  = 1'b1;

  // replacement character U+FFFD as utf-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // one unit of output work: rep_cnt replacements, then pass_cnt raw bytes
  typedef struct packed {
    logic [2:0]      rep_cnt;
    logic [2:0]      pass_cnt;
    logic [3:0][7:0] pass_bytes;
  } cmd_t;

  // sequence length announced by a leader, zero for continuation or illegal
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if (c[7] == 1'b0) begin
      len = 3'd1;
    end else if (c[7:6] == 2'b10) begin
      len = 3'd0;
    end else if (c[7:5] == 3'b110) begin
      len = 3'd2;
    end else if (c[7:4] == 4'b1110) begin
      len = 3'd3;
    end else if (c[7:3] == 5'b11110) begin
      len = 3'd4;
    end
    return len;
  endfunction

  // range checks on a completed sequence: overlong, surrogate, above U+10FFFF
  function automatic logic seq_ok(input logic [2:0] len, input logic [3:0][7:0] b);
    logic [10:0] cp2;
    logic [15:0] cp3;
    logic [20:0] cp4;
    logic        ok;
    cp2 = {b[0][4:0], b[1][5:0]};
    cp3 = {b[0][3:0], b[1][5:0], b[2][5:0]};
    cp4 = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
    if (len == 3'd2) begin
      ok = (cp2 >= 11'h080);
    end else if (len == 3'd3) begin
      ok = (cp3 >= 16'h0800) && !((cp3 >= 16'hD800) && (cp3 <= 16'hDFFF));
    end else begin
      ok = (cp4 >= 21'h10000) && (cp4 <= 21'h10FFFF);
    end
    return ok;
  endfunction

endpackage

### src/utf8_stream_sanitizer.sv
// top level of the utf-8 stream sanitizer
`timescale 1ns / 1ps
//
//  channel  dir  handshake            tdata               tuser / tlast
//  s_*      in   s_tvalid / s_tready  [7:0] data_byte     tuser: req_type
//  m_*      out  m_tvalid / m_tready  [7:0] out_byte      tlast: last_of_run
//
//  a request is taken whenever the two-entry work queue has room;
//  each request that produces bytes leaves one work entry, and the back end
//  drains it at one byte per cycle while m_tready is high; a request yields
//  at most twelve bytes, for four replacement characters.
//  rst is synchronous, active high; it clears the pending sequence, the queue
//  and the output valid flag. held bytes and the output byte are not cleared.
//  output backpressure fills the queue and then drops s_tready.
//
module utf8_stream_sanitizer (
  input  logic       clk,
  input  logic       rst,
  // request side
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] data_byte
  input  logic       s_tuser,   // [0] req_type: data byte or end of stream
  // result side
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // last byte caused by one request
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_valid;
  usan_pkg::cmd_t push_cmd;
  usan_pkg::cmd_t head_cmd;

  // requests are only refused when the work queue is full
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  // classification and sequence tracking
  usan_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_type  (s_tuser),
    .data_byte (s_tdata),
    .push      (push),
    .cmd       (push_cmd)
  );

  // decouples the two halves so each can stall on its own
  usan_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_valid),
    .head_cmd  (head_cmd)
  );

  // byte serializer with the output register
  usan_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (m_tdata),
    .out_last  (m_tlast)
  );

endmodule

### src/usan_front.sv
// front part: accepts requests, tracks the pending sequence, issues output work
`timescale 1ns / 1ps
module usan_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              req_type,
  input  logic [7:0]        data_byte,
  output logic              push,
  output usan_pkg::cmd_t    cmd
);

  logic [3:0][7:0] held_bytes;
  logic [2:0]      held_count;
  logic [2:0]      expected_length;
  logic [2:0]      held_count_next;
  logic [2:0]      expected_length_next;
  logic            wr_en;
  logic [1:0]      wr_idx;
  logic [3:0][7:0] seq;
  logic [2:0]      cnt_inc;
  logic [2:0]      len;
  logic [2:0]      rep0;
  logic            pending;
  logic            is_cont;

  assign pending = (expected_length != 3'd0);
  assign is_cont = (data_byte[7:6] == 2'b10);
  assign cnt_inc = held_count + 3'd1;
  assign len     = usan_pkg::lead_len(data_byte);

  always_comb begin
    seq = held_bytes;
    seq[held_count[1:0]] = data_byte;
  end

  always_comb begin
    cmd                  = '0;
    push                 = 1'b0;
    held_count_next      = held_count;
    expected_length_next = expected_length;
    wr_en                = 1'b0;
    wr_idx               = 2'd0;
    rep0                 = pending ? held_count : 3'd0;
    if (req_type == usan_pkg::REQ_EOS) begin
      cmd.rep_cnt          = held_count;
      push                 = pending;
      held_count_next      = 3'd0;
      expected_length_next = 3'd0;
    end else if (pending && is_cont) begin
      wr_en           = 1'b1;
      wr_idx          = held_count[1:0];
      held_count_next = cnt_inc;
      if (cnt_inc >= expected_length) begin
        push                 = 1'b1;
        held_count_next      = 3'd0;
        expected_length_next = 3'd0;
        if (usan_pkg::seq_ok(expected_length, seq)) begin
          cmd.pass_cnt   = cnt_inc;
          cmd.pass_bytes = seq;
        end else begin
          cmd.rep_cnt = cnt_inc;
        end
      end
    end else begin
      // flush whatever is held, then take the byte fresh
      held_count_next      = 3'd0;
      expected_length_next = 3'd0;
      cmd.rep_cnt          = rep0;
      if (data_byte == 8'h00) begin
        cmd.rep_cnt = rep0 + 3'd1;
      end else if (len == 3'd1) begin
        cmd.pass_cnt      = 3'd1;
        cmd.pass_bytes[0] = data_byte;
      end else if (len == 3'd0) begin
        cmd.rep_cnt = rep0 + 3'd1;
      end else begin
        wr_en                = 1'b1;
        wr_idx               = 2'd0;
        held_count_next      = 3'd1;
        expected_length_next = len;
      end
      push = (cmd.rep_cnt != 3'd0) || (cmd.pass_cnt != 3'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count      <= 3'd0;
      expected_length <= 3'd0;
    end else if (accept) begin
      held_count      <= held_count_next;
      expected_length <= expected_length_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      held_bytes[wr_idx] <= data_byte;
    end
  end

endmodule

### src/usan_fifo.sv
// two-entry queue of output work between front and back
`timescale 1ns / 1ps
module usan_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  usan_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output usan_pkg::cmd_t    head_cmd
);

  usan_pkg::cmd_t                   mem [usan_pkg::QDEPTH];
  logic [usan_pkg::QPTR_W-1:0]      wr_ptr;
  logic [usan_pkg::QPTR_W-1:0]      rd_ptr;
  logic [usan_pkg::QCNT_W-1:0]      count;
  logic                             do_push;
  logic                             do_pop;

  assign full      = (count == usan_pkg::QCNT_W'(usan_pkg::QDEPTH));
  assign not_empty = (count != '0);
  assign head_cmd  = mem[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + usan_pkg::QCNT_W'(1);
        2'b01:   count <= count - usan_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

endmodule

### src/usan_back.sv
// back part: expands output work into single bytes on a registered output
`timescale 1ns / 1ps
module usan_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  usan_pkg::cmd_t    q_cmd,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  logic            active;
  logic [2:0]      rep_left;
  logic [1:0]      sub;
  logic [2:0]      pass_left;
  logic [1:0]      pass_idx;
  logic [3:0][7:0] bytes;
  logic            emit;
  logic            is_last;
  logic [7:0]      byte_sel;

  assign emit    = active && (!out_valid || out_ready);
  assign is_last = ((rep_left == 3'd1) && (sub == 2'd2) && (pass_left == 3'd0)) ||
                   ((rep_left == 3'd0) && (pass_left == 3'd1));
  assign pop     = q_valid && (!active || (emit && is_last));

  always_comb begin
    if (rep_left != 3'd0) begin
      case (sub)
        2'd0:    byte_sel = usan_pkg::REPL_B0;
        2'd1:    byte_sel = usan_pkg::REPL_B1;
        default: byte_sel = usan_pkg::REPL_B2;
      endcase
    end else begin
      byte_sel = bytes[pass_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
      rep_left  <= 3'd0;
      sub       <= 2'd0;
      pass_left <= 3'd0;
      pass_idx  <= 2'd0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        active    <= 1'b1;
        rep_left  <= q_cmd.rep_cnt;
        sub       <= 2'd0;
        pass_left <= q_cmd.pass_cnt;
        pass_idx  <= 2'd0;
      end else if (emit) begin
        if (is_last) begin
          active <= 1'b0;
        end
        if (rep_left != 3'd0) begin
          if (sub == 2'd2) begin
            sub      <= 2'd0;
            rep_left <= rep_left - 3'd1;
          end else begin
            sub <= sub + 2'd1;
          end
        end else begin
          pass_left <= pass_left - 3'd1;
          pass_idx  <= pass_idx + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      bytes <= q_cmd.pass_bytes;
    end
    if (emit) begin
      out_byte <= byte_sel;
      out_last <= is_last;
    end
  end

endmodule

### src/usan_checker.sv
// port-level checks for the utf-8 sanitizer and their binding
`timescale 1ns / 1ps
module usan_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic [7:0] s_tdata,
  input logic       s_tuser,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // reset leaves no result behind
  a_reset_clears_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result changed while stalled");

  // requests are refused only while results are waiting to be taken
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("request side stalled with no result pending");

endmodule

bind utf8_stream_sanitizer usan_checker u_usan_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
